// ===== hdl/timed_stepper_move_generator_defines.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef TIMED_STEPPER_MOVE_GENERATOR_DEFINES_SVH
`define TIMED_STEPPER_MOVE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, clocked on clk, off while rst_n is low
`define TSMG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low
`define TSMG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TSMG_ASSERT_IMPL(lbl, ante, cons)
`define TSMG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/tsmg_pkg.sv =====
package tsmg_pkg;

    // Default sizing
    localparam int STEP_COUNT_BITS_DEF = 16;
    localparam int TIME_BITS_DEF       = 32;
    localparam int US_PER_MS_DEF       = 1000;

    // Fixed field widths
    localparam int DUR_W    = 23;
    localparam int ACTION_W = 2;
    localparam int OUT_W    = 4;
    localparam int OUT_DW   = 8;

    // Request kinds carried on tuser
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd2;

endpackage

// ===== hdl/tsmg_div.sv =====
module tsmg_div #(
    parameter int TIME_BITS = tsmg_pkg::TIME_BITS_DEF,
    parameter int DIV_BITS  = tsmg_pkg::STEP_COUNT_BITS_DEF + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TIME_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0]  divisor,
    output logic                 done,
    output logic [TIME_BITS-1:0] quotient
);
    localparam int CNT_W = $clog2(TIME_BITS + 1);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] quo_reg;
    logic [DIV_BITS-1:0]  rem_reg;
    logic [DIV_BITS-1:0]  div_reg;

    logic [DIV_BITS:0]    trial;
    logic [DIV_BITS:0]    diff;
    logic                 ge;
    logic                 last;

    // Shift in one dividend bit and try the subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[TIME_BITS-1]};
        ge    = trial >= {1'b0, div_reg};
        diff  = trial - {1'b0, div_reg};
        last  = cnt_reg == CNT_W'(TIME_BITS - 1);
    end

    // Sequence the bit steps
    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = run_reg && last;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (last)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Quotient bits shift in behind the dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[TIME_BITS-2:0], ge};
            rem_reg <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/timed_stepper_move_generator.sv =====
// Channel | Dir | Signals                       | Carries
// s       | in  | s_tvalid s_tready s_tdata s_tuser | one request: tick, start or cancel
// m       | out | m_tvalid m_tready m_tdata     | one result per request
//
// A tick that needs a new step interval waits in ST_DIV for the
// bit-serial divider (one quotient bit per cycle); other requests do not.
// One request is in work at a time; s_tready is high only while idle.
// The result sits in an output register, so a new request is taken while it waits.
// rst_n clears the move state and pins at once; no clearing pass is needed.
`include "timed_stepper_move_generator_defines.svh"

module timed_stepper_move_generator #(
    parameter int STEP_COUNT_BITS = tsmg_pkg::STEP_COUNT_BITS_DEF,
    parameter int TIME_BITS       = tsmg_pkg::TIME_BITS_DEF,
    parameter int US_PER_MS       = tsmg_pkg::US_PER_MS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // step_count, direction, duration_ms, zero fill
    input  logic [((STEP_COUNT_BITS + 1 + tsmg_pkg::DUR_W + 7) / 8) * 8 - 1:0] s_tdata,
    // action
    input  logic [tsmg_pkg::ACTION_W-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // accepted, step_level, dir_level, busy_res, zero fill
    output logic [tsmg_pkg::OUT_DW-1:0] m_tdata
);
    import tsmg_pkg::*;

    localparam int EW       = STEP_COUNT_BITS + 2;
    localparam int DIV_BITS = STEP_COUNT_BITS + 1;
    localparam int CW       = (STEP_COUNT_BITS > DUR_W) ? STEP_COUNT_BITS : DUR_W;
    localparam int USW      = $clog2(US_PER_MS + 1);
    localparam int PW       = DUR_W + USW;
    localparam int XW       = (PW > TIME_BITS) ? PW : TIME_BITS + 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_CMP  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    logic                         busy_reg, busy_next;
    logic                         cancel_reg, cancel_next;
    logic signed [EW-1:0]         edges_reg, edges_next;
    logic [TIME_BITS-1:0]         time_reg, time_next;
    logic [TIME_BITS-1:0]         since_reg, since_next;
    logic                         step_pin_reg, step_pin_next;
    logic                         dir_pin_reg, dir_pin_next;
    logic                         m_tvalid_reg, m_tvalid_next;

    logic [STEP_COUNT_BITS-1:0]   steps_reg;
    logic                         dir_in_reg;
    logic [DUR_W-1:0]             dur_reg;
    logic                         acc_reg, acc_next;
    logic [TIME_BITS-1:0]         wanted_reg, wanted_next;
    logic [OUT_DW-1:0]            m_tdata_reg, m_tdata_next;

    logic                         in_fire;
    logic                         edges_pos;
    logic [TIME_BITS-1:0]         since_inc;
    logic [XW-1:0]                prod_x;
    logic [TIME_BITS-1:0]         dur_us;
    logic                         too_many;
    logic                         div_start;
    logic                         div_done;
    logic [TIME_BITS-1:0]         div_quo;

    // Step interval divider
    tsmg_div #(
        .TIME_BITS (TIME_BITS),
        .DIV_BITS  (DIV_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (time_reg),
        .divisor  (edges_reg[DIV_BITS-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Decode shared values
    always_comb
    begin
        in_fire   = s_tvalid && s_tready;
        edges_pos = !edges_reg[EW-1] && (edges_reg != '0);
        since_inc = (since_reg == '1) ? since_reg : since_reg + TIME_BITS'(1);
        prod_x    = XW'(dur_reg) * XW'(US_PER_MS);
        dur_us    = (prod_x > {{(XW - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}})
                    ? {TIME_BITS{1'b1}} : prod_x[TIME_BITS-1:0];
        too_many  = CW'(steps_reg) > CW'(dur_reg);
    end

    // Advance the request sequencer
    always_comb
    begin
        state_next    = state_reg;
        busy_next     = busy_reg;
        cancel_next   = cancel_reg;
        edges_next    = edges_reg;
        time_next     = time_reg;
        since_next    = since_reg;
        step_pin_next = step_pin_reg;
        dir_pin_next  = dir_pin_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        acc_next      = acc_reg;
        wanted_next   = wanted_reg;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_tuser)
                        ACT_TICK:
                        begin
                            acc_next   = busy_reg;
                            state_next = ST_DONE;
                            if (busy_reg)
                            begin
                                if (cancel_reg || (!edges_pos && time_reg == '0))
                                begin
                                    // End the move and drop both pins
                                    cancel_next   = 1'b0;
                                    step_pin_next = 1'b0;
                                    dir_pin_next  = 1'b0;
                                    busy_next     = 1'b0;
                                end
                                else
                                begin
                                    since_next = since_inc;
                                    if (edges_pos)
                                    begin
                                        div_start  = 1'b1;
                                        state_next = ST_DIV;
                                    end
                                    else
                                    begin
                                        wanted_next = time_reg;
                                        state_next  = ST_CMP;
                                    end
                                end
                            end
                        end
                        ACT_START:
                        begin
                            state_next = ST_MUL;
                        end
                        ACT_CANCEL:
                        begin
                            acc_next    = busy_reg;
                            cancel_next = cancel_reg || busy_reg;
                            state_next  = ST_DONE;
                        end
                        default:
                        begin
                            acc_next   = 1'b0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                // Load the move unless busy or too many steps
                if (busy_reg || too_many)
                begin
                    acc_next = 1'b0;
                end
                else
                begin
                    acc_next      = 1'b1;
                    busy_next     = 1'b1;
                    edges_next    = {1'b0, steps_reg, 1'b0};
                    time_next     = dur_us;
                    since_next    = '0;
                    step_pin_next = 1'b0;
                    dir_pin_next  = dir_in_reg;
                end
                state_next = ST_DONE;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    wanted_next = div_quo;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP:
            begin
                // Take an edge once the interval has run out
                if (since_reg >= wanted_reg)
                begin
                    step_pin_next = step_pin_reg ^ edges_pos;
                    edges_next    = edges_reg - EW'(1);
                    time_next     = (time_reg < since_reg) ? '0 : time_reg - since_reg;
                    since_next    = '0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(OUT_DW - OUT_W){1'b0}},
                                     busy_reg, dir_pin_reg, step_pin_reg, acc_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            busy_reg     <= 1'b0;
            cancel_reg   <= 1'b0;
            edges_reg    <= '0;
            time_reg     <= '0;
            since_reg    <= '0;
            step_pin_reg <= 1'b0;
            dir_pin_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            busy_reg     <= busy_next;
            cancel_reg   <= cancel_next;
            edges_reg    <= edges_next;
            time_reg     <= time_next;
            since_reg    <= since_next;
            step_pin_reg <= step_pin_next;
            dir_pin_reg  <= dir_pin_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Capture request fields and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            steps_reg  <= s_tdata[STEP_COUNT_BITS-1:0];
            dir_in_reg <= s_tdata[STEP_COUNT_BITS];
            dur_reg    <= s_tdata[STEP_COUNT_BITS + DUR_W:STEP_COUNT_BITS + 1];
        end
        acc_reg     <= acc_next;
        wanted_reg  <= wanted_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TSMG_ASSERT_IMPL(a_idle_pins_low, !busy_reg, !step_pin_reg && !dir_pin_reg)
    `TSMG_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)
    `TSMG_ASSERT_IMPL(a_edges_floor, edges_reg[EW-1], edges_reg == {EW{1'b1}})
    `TSMG_ASSERT_IMPL(a_div_done_in_div, div_done, state_reg == ST_DIV)

endmodule
